// File: hw/rtl/multi_timer_expiry_queue_defines.svh
// Assertion macros shared by the timer queue RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef MULTI_TIMER_EXPIRY_QUEUE_DEFINES_SVH
`define MULTI_TIMER_EXPIRY_QUEUE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MTEQ_ASSERT_HOLD(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define MTEQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MTEQ_ASSERT_HOLD(label, clk, rstn, prop)
`define MTEQ_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// File: hw/rtl/mteq_pkg.sv
// Types, codes and constants of the timer expiry queue.
// Depends on nothing; imported by every module of the block.
`default_nettype none
package mteq_pkg;
    localparam int NUM_TIMERS_DEF = 16;
    localparam int MAX_RESULTS    = 16;
    localparam int CMD_FIFO_DEPTH = 2;
    localparam logic [63:0] NO_DUE_TICKS = '1;

    typedef enum logic [2:0] {
        OP_TICK         = 3'd0,
        OP_ARM_ONCE     = 3'd1,
        OP_ARM_PERIODIC = 3'd2,
        OP_CANCEL       = 3'd3,
        OP_CANCEL_ALL   = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        RK_ARMED     = 3'd0,
        RK_FULL      = 3'd1,
        RK_CANCELLED = 3'd2,
        RK_FIRED     = 3'd3,
        RK_NONE_DUE  = 3'd4,
        RK_CLEARED   = 3'd5
    } result_kind_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] delay_ms;
        logic [31:0] target_id;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [31:0] timer_id;
        logic [63:0] next_due;
        logic        last_of_run;
    } out_item_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] delay_ms;
        logic [31:0] target_id;
    } cmd_t;

    typedef struct packed {
        logic        periodic;
        logic [31:0] ident;
        logic [63:0] due;
        logic [31:0] period;
    } slot_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_ACT  = 2'd2,
        ST_EMIT = 2'd3
    } eng_state_t;
endpackage
`default_nettype wire

// File: hw/rtl/mteq_front.sv
// Front end: takes input requests, drops unknown kinds, forms commands.
// Depends on mteq_pkg.
`default_nettype none
module mteq_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  mteq_pkg::in_item_t     s_item,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output mteq_pkg::cmd_t         push_cmd
);
    import mteq_pkg::*;

    logic known;

    // Unknown kinds are taken and quietly discarded.
    always_comb begin
        known = s_item.kind inside {OP_TICK, OP_ARM_ONCE, OP_ARM_PERIODIC, OP_CANCEL,
                                    OP_CANCEL_ALL};
        s_ready            = push_ready;
        push_valid         = s_valid && known;
        push_cmd.op        = op_t'(s_item.kind);
        push_cmd.delay_ms  = s_item.delay_ms;
        push_cmd.target_id = s_item.target_id;
    end

    `include "multi_timer_expiry_queue_defines.svh"
    `MTEQ_ASSERT_HOLD(a_push_known, aclk, aresetn, !push_valid || s_valid)
    `MTEQ_ASSERT_HOLD(a_ready_follows, aclk, aresetn, s_ready == push_ready)
    `MTEQ_ASSERT_HOLD(a_no_push_unknown, aclk, aresetn, !(push_valid && !known))
endmodule
`default_nettype wire

// File: hw/rtl/mteq_cmd_fifo.sv
// Short command queue between the front end and the engine.
// Depends on mteq_pkg.
`default_nettype none
module mteq_cmd_fifo #(
    parameter int DEPTH = mteq_pkg::CMD_FIFO_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push_valid,
    output logic             push_ready,
    input  mteq_pkg::cmd_t   push_cmd,
    output logic             pop_valid,
    input  wire logic        pop_ready,
    output mteq_pkg::cmd_t   pop_cmd
);
    import mteq_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          buf_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = buf_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            buf_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `include "multi_timer_expiry_queue_defines.svh"
    `MTEQ_ASSERT_HOLD(a_count_bound, aclk, aresetn, count_reg <= CW'(DEPTH))
    `MTEQ_ASSERT_NEXT(a_push_counts, aclk, aresetn, do_push && !do_pop,
                      count_reg == $past(count_reg) + 1'b1)
    `MTEQ_ASSERT_NEXT(a_pop_counts, aclk, aresetn, do_pop && !do_push,
                      count_reg == $past(count_reg) - 1'b1)
endmodule
`default_nettype wire

// File: hw/rtl/mteq_engine.sv
// Back end: holds the timer slots and carries out commands by scanning them.
// Depends on mteq_pkg.
`default_nettype none
module mteq_engine #(
    parameter int NUM_TIMERS = mteq_pkg::NUM_TIMERS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          pop_valid,
    output logic               pop_ready,
    input  mteq_pkg::cmd_t     pop_cmd,
    output logic               m_valid,
    input  wire logic          m_ready,
    output mteq_pkg::out_item_t m_item
);
    import mteq_pkg::*;

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int FW = $clog2(MAX_RESULTS + 1);

    eng_state_t state_reg, state_next, after_reg, after_next;
    logic       phase_reg, phase_next;
    cmd_t       cmd_reg, cmd_next;
    logic [63:0] time_reg, time_next;
    logic [31:0] next_id_reg, next_id_next;
    logic [31:0] pend_id_reg, pend_id_next;
    logic        pend_reg, pend_next;
    logic [FW-1:0] fired_reg, fired_next;
    logic [NUM_TIMERS-1:0] valid_reg, valid_next;
    out_item_t   res_reg, res_next;
    out_item_t   out_reg;
    logic        out_valid_reg;

    slot_t         slot_mem [NUM_TIMERS];
    slot_t         rd_data_reg;
    logic [IW-1:0] rd_idx_reg;
    logic          rd_valid_reg;
    logic [CW-1:0] cnt_reg;
    logic          issue, scan_start, scan_done;

    logic          mem_we;
    logic [IW-1:0] mem_wa;
    slot_t         mem_wd;

    // Scan results
    logic          any_reg, pick_reg, free_reg, match_reg;
    logic [63:0]   min_reg, pick_due_reg;
    logic [31:0]   pick_id_reg, pick_period_reg;
    logic          pick_periodic_reg;
    logic [IW-1:0] pick_idx_reg, free_idx_reg, match_idx_reg;

    logic          out_load, fire_ok, ent_valid;
    logic [63:0]   nd_val;
    logic [31:0]   arm_period;

    assign issue     = (state_reg == ST_SCAN) && !scan_start && (cnt_reg < CW'(NUM_TIMERS));
    assign scan_done = (state_reg == ST_SCAN) && !scan_start &&
                       (cnt_reg == CW'(NUM_TIMERS)) && !rd_valid_reg;
    assign ent_valid = valid_reg[rd_idx_reg];
    assign fire_ok   = pick_reg && (fired_reg < FW'(MAX_RESULTS));
    assign m_valid   = out_valid_reg;
    assign m_item    = out_reg;

    always_comb begin
        if (!any_reg) begin
            nd_val = NO_DUE_TICKS;
        end else if (min_reg <= time_reg) begin
            nd_val = '0;
        end else begin
            nd_val = min_reg - time_reg;
        end
    end

    always_comb begin
        arm_period = cmd_reg.delay_ms;
        if (cmd_reg.op == OP_ARM_PERIODIC && cmd_reg.delay_ms == '0) begin
            arm_period = 32'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            after_reg     <= ST_IDLE;
            phase_reg     <= 1'b0;
            time_reg      <= '0;
            next_id_reg   <= 32'd1;
            pend_reg      <= 1'b0;
            fired_reg     <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            state_reg    <= state_next;
            after_reg    <= after_next;
            phase_reg    <= phase_next;
            time_reg     <= time_next;
            next_id_reg  <= next_id_next;
            pend_reg     <= pend_next;
            fired_reg    <= fired_next;
            valid_reg    <= valid_next;
            rd_valid_reg <= issue;
            if (scan_start) begin
                cnt_reg <= '0;
            end else if (issue) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        pend_id_reg <= pend_id_next;
        res_reg     <= res_next;
        if (out_load) begin
            out_reg <= res_reg;
        end
    end

    // Slot memory: one read port for the scan, one write port for updates.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= slot_mem[cnt_reg[IW-1:0]];
        rd_idx_reg  <= cnt_reg[IW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (scan_start) begin
            any_reg   <= 1'b0;
            pick_reg  <= 1'b0;
            free_reg  <= 1'b0;
            match_reg <= 1'b0;
        end else if (rd_valid_reg) begin
            if (ent_valid && (!any_reg || rd_data_reg.due < min_reg)) begin
                any_reg <= 1'b1;
                min_reg <= rd_data_reg.due;
            end
            if (ent_valid && rd_data_reg.due <= time_reg &&
                (!pick_reg || rd_data_reg.due < pick_due_reg ||
                 (rd_data_reg.due == pick_due_reg && rd_data_reg.ident < pick_id_reg))) begin
                pick_reg          <= 1'b1;
                pick_idx_reg      <= rd_idx_reg;
                pick_due_reg      <= rd_data_reg.due;
                pick_id_reg       <= rd_data_reg.ident;
                pick_periodic_reg <= rd_data_reg.periodic;
                pick_period_reg   <= rd_data_reg.period;
            end
            if (!ent_valid && !free_reg) begin
                free_reg     <= 1'b1;
                free_idx_reg <= rd_idx_reg;
            end
            if (ent_valid && rd_data_reg.ident == cmd_reg.target_id && !match_reg) begin
                match_reg     <= 1'b1;
                match_idx_reg <= rd_idx_reg;
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        after_next   = after_reg;
        phase_next   = phase_reg;
        cmd_next     = cmd_reg;
        time_next    = time_reg;
        next_id_next = next_id_reg;
        pend_id_next = pend_id_reg;
        pend_next    = pend_reg;
        fired_next   = fired_reg;
        valid_next   = valid_reg;
        res_next     = res_reg;
        pop_ready    = 1'b0;
        scan_start   = 1'b0;
        out_load     = 1'b0;
        mem_we       = 1'b0;
        mem_wa       = pick_idx_reg;
        mem_wd       = '0;
        case (state_reg)
            ST_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    cmd_next   = pop_cmd;
                    phase_next = 1'b0;
                    case (pop_cmd.op)
                        OP_CANCEL_ALL: begin
                            valid_next           = '0;
                            res_next.result_kind = 3'(RK_CLEARED);
                            res_next.timer_id    = '0;
                            res_next.next_due    = NO_DUE_TICKS;
                            res_next.last_of_run = 1'b1;
                            after_next           = ST_IDLE;
                            state_next           = ST_EMIT;
                        end
                        OP_TICK: begin
                            time_next  = time_reg + 64'd1;
                            fired_next = '0;
                            pend_next  = 1'b0;
                            scan_start = 1'b1;
                            state_next = ST_SCAN;
                        end
                        default: begin
                            scan_start = 1'b1;
                            state_next = ST_SCAN;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_ACT;
                end
            end
            ST_ACT: begin
                res_next.next_due    = nd_val;
                res_next.last_of_run = 1'b1;
                after_next           = ST_IDLE;
                state_next           = ST_EMIT;
                case (cmd_reg.op)
                    OP_TICK: begin
                        res_next.result_kind = 3'(RK_NONE_DUE);
                        res_next.timer_id    = '0;
                        if (pend_reg) begin
                            res_next.result_kind = 3'(RK_FIRED);
                            res_next.timer_id    = pend_id_reg;
                            res_next.last_of_run = !fire_ok;
                        end
                        if (fire_ok) begin
                            if (pick_periodic_reg) begin
                                mem_we          = 1'b1;
                                mem_wa          = pick_idx_reg;
                                mem_wd.periodic = 1'b1;
                                mem_wd.ident    = pick_id_reg;
                                mem_wd.period   = pick_period_reg;
                                mem_wd.due      = time_reg + 64'(pick_period_reg);
                            end else begin
                                valid_next[pick_idx_reg] = 1'b0;
                            end
                            pend_id_next = pick_id_reg;
                            pend_next    = 1'b1;
                            fired_next   = fired_reg + 1'b1;
                            after_next   = ST_SCAN;
                            if (!pend_reg) begin
                                scan_start = 1'b1;
                                state_next = ST_SCAN;
                            end
                        end
                    end
                    OP_ARM_ONCE, OP_ARM_PERIODIC: begin
                        res_next.result_kind = 3'(RK_ARMED);
                        res_next.timer_id    = pend_id_reg;
                        if (!phase_reg) begin
                            if (free_reg) begin
                                mem_we          = 1'b1;
                                mem_wa          = free_idx_reg;
                                mem_wd.periodic = cmd_reg.op == OP_ARM_PERIODIC;
                                mem_wd.ident    = next_id_reg;
                                mem_wd.period   = (cmd_reg.op == OP_ARM_PERIODIC) ?
                                                  arm_period : '0;
                                mem_wd.due      = time_reg + 64'(arm_period);
                                valid_next[free_idx_reg] = 1'b1;
                                pend_id_next = next_id_reg;
                                next_id_next = next_id_reg + 32'd1;
                                phase_next   = 1'b1;
                                scan_start   = 1'b1;
                                state_next   = ST_SCAN;
                            end else begin
                                res_next.result_kind = 3'(RK_FULL);
                                res_next.timer_id    = '0;
                            end
                        end
                    end
                    default: begin
                        res_next.result_kind = 3'(RK_CANCELLED);
                        res_next.timer_id    = cmd_reg.target_id;
                        if (!phase_reg) begin
                            if (match_reg) begin
                                valid_next[match_idx_reg] = 1'b0;
                            end
                            phase_next = 1'b1;
                            scan_start = 1'b1;
                            state_next = ST_SCAN;
                        end
                    end
                endcase
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = after_reg;
                    if (after_reg == ST_SCAN) begin
                        scan_start = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `include "multi_timer_expiry_queue_defines.svh"
    `MTEQ_ASSERT_HOLD(a_no_overwrite, aclk, aresetn, !out_load || !out_valid_reg || m_ready)
    `MTEQ_ASSERT_NEXT(a_pop_busy, aclk, aresetn, pop_valid && pop_ready,
                      state_reg != ST_IDLE)
    `MTEQ_ASSERT_HOLD(a_read_in_scan, aclk, aresetn, !rd_valid_reg || state_reg == ST_SCAN)
    `MTEQ_ASSERT_HOLD(a_fire_bound, aclk, aresetn, fired_reg <= FW'(MAX_RESULTS))
endmodule
`default_nettype wire

// File: hw/rtl/multi_timer_expiry_queue.sv
// Timer expiry queue: a table of one-shot and periodic timers counted in ticks.
// Requests (s_valid/s_ready, s_item) are tick, arm one-shot, arm periodic,
// cancel by id and cancel all; unknown kinds are taken and dropped.
// Results (m_valid/m_ready, m_item) give the kind, the timer id, the ticks to
// the next expiry and a flag on the last result of each request.
// Timing: requests pass a two-entry command queue to an engine that scans the
// slot memory one slot per cycle. Cancel all needs no scan; cancel scans the
// slots twice, arm twice when a slot is free and once when the table is full,
// a tick with nothing due once, and a tick that fires timers once per fired
// timer and once more. One request is worked at a time.
// Reset clears time, marks all slots free and sets the first id to 1; no
// clearing pass is needed. A stalled receiver holds the result in the output
// register; the engine then waits, the queue fills and s_ready falls.
// Depends on mteq_pkg, mteq_front, mteq_cmd_fifo and mteq_engine.
`default_nettype none
module multi_timer_expiry_queue #(
    parameter int NUM_TIMERS = mteq_pkg::NUM_TIMERS_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  mteq_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  wire logic           m_ready,
    output mteq_pkg::out_item_t m_item
);
    import mteq_pkg::*;

    logic push_valid, push_ready, pop_valid, pop_ready;
    cmd_t push_cmd, pop_cmd;

    mteq_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .push_valid(push_valid), .push_ready(push_ready), .push_cmd(push_cmd)
    );

    mteq_cmd_fifo #(.DEPTH(CMD_FIFO_DEPTH)) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .push_valid(push_valid), .push_ready(push_ready), .push_cmd(push_cmd),
        .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_cmd(pop_cmd)
    );

    mteq_engine #(.NUM_TIMERS(NUM_TIMERS)) u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_cmd(pop_cmd),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );
endmodule
`default_nettype wire
